// ===== hdl/htc_pkg.sv =====
// Package for the humidity and temperature compensation block.
// Holds the input and result word types and the fixed conversion constants.
// Used by every module in hdl; depends on nothing.
package htc_pkg;

    localparam int RAW_T_W   = 14;
    localparam int RAW_H_W   = 12;
    localparam int OFFSET_W  = 13;
    localparam int T_OUT_W   = 12;
    localparam int H_OUT_W   = 10;
    localparam int T100_W    = 16;
    localparam int SUM_W     = 44;
    localparam int CLAMP_W   = 40;
    localparam int STAGES    = 7;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -13'sd3970;
    localparam logic signed [T100_W-1:0]   T_REF        = 16'sd2500;

    // Multiply by this and shift right by TEN_SHIFT to divide by ten.
    localparam logic [15:0] TEN_RECIP = 16'd52429;
    localparam int          TEN_SHIFT = 19;

    localparam logic [19:0] K_BASE    = 20'd1000000;
    localparam logic [12:0] K_SLOPE   = 13'd8000;
    localparam logic [28:0] LIN_COEF  = 29'd367000000;
    localparam logic [13:0] SQ_COEF   = 14'd15955;
    localparam logic signed [SUM_W-1:0] RH_BIAS = -44'sd20468000000;

    localparam logic signed [SUM_W-1:0] RH_FLOOR = 44'sd100000000;
    localparam logic signed [SUM_W-1:0] RH_CEIL  = 44'sd1000000000000;
    localparam logic [CLAMP_W-1:0]      RH_DIV   = 40'd1000000000;

    // Approximates 2^50 / 1e9 for the quotient estimate.
    localparam logic [20:0] DIV_RECIP = 21'd1125899;
    localparam int          DIV_SHIFT = 30;

    typedef struct packed {
        logic [RAW_T_W-1:0] raw_temperature;
        logic [RAW_H_W-1:0] raw_humidity;
    } in_word_t;

    typedef struct packed {
        logic signed [T_OUT_W-1:0] temperature_tenths;
        logic [H_OUT_W-1:0]        humidity_tenths;
    } out_word_t;

endpackage

// ===== hdl/htc_poly.sv =====
// First four pipeline stages: temperature offset, products and the humidity polynomial sum.
// Also produces the temperature in tenths. Depends on htc_pkg.
module htc_poly (
    input  logic                                  aclk,
    input  logic [3:0]                            stage_en,
    input  htc_pkg::in_word_t                     in_word,
    input  logic signed [htc_pkg::OFFSET_W-1:0]   temp_offset,
    output logic signed [htc_pkg::SUM_W-1:0]      rh_sum,
    output logic signed [htc_pkg::T_OUT_W-1:0]    temp_tenths
);

    logic signed [htc_pkg::T100_W-1:0] t100_reg;
    logic signed [htc_pkg::T100_W-1:0] dt1_reg;
    logic [htc_pkg::RAW_H_W-1:0]       h1_reg;

    logic                              tneg2_reg;
    logic [30:0]                       tscale2_reg;
    logic [23:0]                       hsq2_reg;
    logic [25:0]                       k2_reg;
    logic [40:0]                       lin2_reg;
    logic signed [htc_pkg::T100_W-1:0] dt2_reg;

    logic [37:0]                       p1_3_reg;
    logic signed [41:0]                p2_3_reg;
    logic [40:0]                       lin3_reg;
    logic signed [htc_pkg::T_OUT_W-1:0] t3_reg;

    logic signed [htc_pkg::SUM_W-1:0]  sum4_reg;
    logic signed [htc_pkg::T_OUT_W-1:0] t4_reg;

    logic signed [htc_pkg::T100_W-1:0] t100_next;
    logic signed [htc_pkg::T100_W-1:0] dt1_next;
    logic [14:0]                       tmag;
    logic [11:0]                       tq;
    logic signed [htc_pkg::SUM_W-1:0]  sum4_next;

    always_comb begin
        t100_next = $signed({2'b00, in_word.raw_temperature})
                  + htc_pkg::T100_W'(temp_offset);
        dt1_next  = t100_next - htc_pkg::T_REF;
        tmag      = t100_reg[htc_pkg::T100_W-1] ? 15'(-t100_reg) : t100_reg[14:0];
        tq        = tscale2_reg[htc_pkg::TEN_SHIFT +: 12];
        sum4_next = htc_pkg::RH_BIAS
                  + $signed({3'b000, lin3_reg})
                  - $signed({6'd0, p1_3_reg})
                  + htc_pkg::SUM_W'(p2_3_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t100_reg <= t100_next;
            dt1_reg  <= dt1_next;
            h1_reg   <= in_word.raw_humidity;
        end
        if (stage_en[1]) begin
            tneg2_reg   <= t100_reg[htc_pkg::T100_W-1];
            tscale2_reg <= 31'(tmag) * 31'(htc_pkg::TEN_RECIP);
            hsq2_reg    <= 24'(h1_reg) * 24'(h1_reg);
            k2_reg      <= 26'(htc_pkg::K_BASE) + 26'(h1_reg) * 26'(htc_pkg::K_SLOPE);
            lin2_reg    <= 41'(h1_reg) * 41'(htc_pkg::LIN_COEF);
            dt2_reg     <= dt1_reg;
        end
        if (stage_en[2]) begin
            p1_3_reg <= 38'(hsq2_reg) * 38'(htc_pkg::SQ_COEF);
            p2_3_reg <= 42'(dt2_reg) * $signed({16'd0, k2_reg});
            lin3_reg <= lin2_reg;
            t3_reg   <= tneg2_reg ? 12'(-tq) : tq;
        end
        if (stage_en[3]) begin
            sum4_reg <= sum4_next;
            t4_reg   <= t3_reg;
        end
    end

    assign rh_sum      = sum4_reg;
    assign temp_tenths = t4_reg;

endmodule

// ===== hdl/htc_scale.sv =====
// Last three pipeline stages: humidity clamp and division by 1e9 into tenths of a percent.
// The divide is a reciprocal estimate followed by a one-step correction. Depends on htc_pkg.
module htc_scale (
    input  logic                                  aclk,
    input  logic [2:0]                            stage_en,
    input  logic signed [htc_pkg::SUM_W-1:0]      rh_sum,
    input  logic signed [htc_pkg::T_OUT_W-1:0]    temp_in,
    output htc_pkg::out_word_t                    out_word
);

    logic [htc_pkg::CLAMP_W-1:0]        v5_reg;
    logic signed [htc_pkg::T_OUT_W-1:0] t5_reg;
    logic [htc_pkg::CLAMP_W-1:0]        v6_reg;
    logic [htc_pkg::H_OUT_W-1:0]        q6_reg;
    logic signed [htc_pkg::T_OUT_W-1:0] t6_reg;
    htc_pkg::out_word_t                 out7_reg;

    logic [htc_pkg::CLAMP_W-1:0] v5_next;
    logic [40:0]                 est_prod;
    logic [htc_pkg::CLAMP_W-1:0] rem;
    logic [htc_pkg::H_OUT_W-1:0] q7_next;

    always_comb begin
        if (rh_sum > htc_pkg::RH_CEIL) begin
            v5_next = htc_pkg::RH_CEIL[htc_pkg::CLAMP_W-1:0];
        end else if (rh_sum < htc_pkg::RH_FLOOR) begin
            v5_next = htc_pkg::RH_FLOOR[htc_pkg::CLAMP_W-1:0];
        end else begin
            v5_next = rh_sum[htc_pkg::CLAMP_W-1:0];
        end
        est_prod = 41'(v5_reg[htc_pkg::CLAMP_W-1:20]) * 41'(htc_pkg::DIV_RECIP);
        rem      = v6_reg - htc_pkg::CLAMP_W'(q6_reg) * htc_pkg::RH_DIV;
        q7_next  = (rem >= htc_pkg::RH_DIV) ? q6_reg + 10'd1 : q6_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            v5_reg <= v5_next;
            t5_reg <= temp_in;
        end
        if (stage_en[1]) begin
            v6_reg <= v5_reg;
            q6_reg <= est_prod[htc_pkg::DIV_SHIFT +: htc_pkg::H_OUT_W];
            t6_reg <= t5_reg;
        end
        if (stage_en[2]) begin
            out7_reg.temperature_tenths <= t6_reg;
            out7_reg.humidity_tenths    <= q7_next;
        end
    end

    assign out_word = out7_reg;

endmodule

// ===== hdl/humidity_temperature_compensation_top.sv =====
// Top level of the humidity and temperature compensation block.
// Holds the offset register and the pipeline flow control; depends on htc_pkg,
// htc_poly and htc_scale.
//
// Each input word on s_data carries a raw 14-bit temperature code and a raw
// 12-bit humidity code. Each result word on m_data carries the temperature and
// the compensated relative humidity, both in tenths and truncated toward zero.
// Both channels use valid and ready handshakes.
// The temperature offset is written through cfg_valid and cfg_data; cfg_ready
// is always high, and the offset should be changed only while the pipeline is
// empty.
// The datapath is a seven-stage pipeline: an accepted input word passes the
// stage registers in order, and m_valid rises when its result word reaches the
// last stage. One word can be accepted every cycle while m_ready stays high.
// When the receiver holds m_ready low, the last stage holds its word and the
// earlier stages keep filling empty slots until the pipeline is full; then
// s_ready falls. Nothing is dropped or repeated.
// A synchronous reset on aresetn empties the pipeline and restores the offset
// to -39.70 degrees.
module humidity_temperature_compensation_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  htc_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output htc_pkg::out_word_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [htc_pkg::OFFSET_W-1:0]        cfg_data
);

    logic signed [htc_pkg::OFFSET_W-1:0] offset_reg;
    logic [htc_pkg::STAGES-1:0]          vld_reg;
    logic [htc_pkg::STAGES-1:0]          vld_next;
    logic [htc_pkg::STAGES-1:0]          stage_en;

    logic signed [htc_pkg::SUM_W-1:0]    rh_sum;
    logic signed [htc_pkg::T_OUT_W-1:0]  temp_tenths;

    always_comb begin
        stage_en[htc_pkg::STAGES-1] = ~vld_reg[htc_pkg::STAGES-1] | m_ready;
        for (int i = htc_pkg::STAGES - 2; i >= 0; i--) begin
            stage_en[i] = ~vld_reg[i] | stage_en[i+1];
        end
        vld_next = vld_reg;
        if (stage_en[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < htc_pkg::STAGES; i++) begin
            if (stage_en[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            offset_reg <= htc_pkg::OFFSET_RESET;
        end else begin
            vld_reg <= vld_next;
            if (cfg_valid) begin
                offset_reg <= $signed(cfg_data);
            end
        end
    end

    htc_poly u_poly (
        .aclk        (aclk),
        .stage_en    (stage_en[3:0]),
        .in_word     (s_data),
        .temp_offset (offset_reg),
        .rh_sum      (rh_sum),
        .temp_tenths (temp_tenths)
    );

    htc_scale u_scale (
        .aclk     (aclk),
        .stage_en (stage_en[6:4]),
        .rh_sum   (rh_sum),
        .temp_in  (temp_tenths),
        .out_word (m_data)
    );

    assign s_ready   = stage_en[0];
    assign m_valid   = vld_reg[htc_pkg::STAGES-1];
    assign cfg_ready = 1'b1;

endmodule

// ===== sim/humidity_temperature_compensation_top_tb.sv =====
// Self-checking testbench for humidity_temperature_compensation_top.
// Predicts every result word from its own integer model and checks the words in order.
// Depends on htc_pkg and the block's RTL only.
module humidity_temperature_compensation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    htc_pkg::in_word_t            s_data = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    htc_pkg::out_word_t           m_data;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [htc_pkg::OFFSET_W-1:0] cfg_data = '0;

    logic                                hold_results = 1'b0;
    int unsigned                         send_idle_pct = 0;
    int unsigned                         recv_idle_pct = 0;
    int unsigned                         mismatch_count = 0;
    logic signed [htc_pkg::OFFSET_W-1:0] offset_now = htc_pkg::OFFSET_RESET;
    htc_pkg::out_word_t                  expected_readings[$];
    htc_pkg::out_word_t                  oldest_reading;

    humidity_temperature_compensation_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic htc_pkg::out_word_t compensate_reading(
        input htc_pkg::in_word_t w,
        input logic signed [htc_pkg::OFFSET_W-1:0] ofs);
        longint             t100;
        longint             h;
        longint             rh;
        htc_pkg::out_word_t r;
        t100 = longint'(w.raw_temperature) + longint'(ofs);
        h    = longint'(w.raw_humidity);
        rh   = -64'sd20468000000 + 64'sd367000000 * h - 64'sd15955 * h * h
               + (t100 - 64'sd2500) * (64'sd1000000 + 64'sd8000 * h);
        if (rh > 64'sd1000000000000) rh = 64'sd1000000000000;
        if (rh < 64'sd100000000) rh = 64'sd100000000;
        r.temperature_tenths = htc_pkg::T_OUT_W'(t100 / 10);
        r.humidity_tenths    = htc_pkg::H_OUT_W'(rh / 64'sd1000000000);
        return r;
    endfunction

    // Result side: checks each accepted word, then picks the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result word with none expected, actual %p", $time, m_data);
            end else begin
                oldest_reading = expected_readings.pop_front();
                if (m_data.temperature_tenths !== oldest_reading.temperature_tenths) begin
                    mismatch_count++;
                    $display("%0t ns: temperature_tenths expected %0d actual %0d", $time,
                             oldest_reading.temperature_tenths, m_data.temperature_tenths);
                end
                if (m_data.humidity_tenths !== oldest_reading.humidity_tenths) begin
                    mismatch_count++;
                    $display("%0t ns: humidity_tenths expected %0d actual %0d", $time,
                             oldest_reading.humidity_tenths, m_data.humidity_tenths);
                end
            end
        end
        if (hold_results) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_reading(input logic [htc_pkg::RAW_T_W-1:0] raw_t,
                                input logic [htc_pkg::RAW_H_W-1:0] raw_h);
        htc_pkg::in_word_t w;
        w.raw_temperature = raw_t;
        w.raw_humidity    = raw_h;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        expected_readings.push_back(compensate_reading(w, offset_now));
    endtask

    task automatic send_random_reading();
        logic [htc_pkg::RAW_T_W-1:0] raw_t;
        logic [htc_pkg::RAW_H_W-1:0] raw_h;
        case ($urandom_range(7))
            0: begin
                raw_t = $urandom_range(1) ? '1 : '0;
                raw_h = $urandom_range(1) ? '1 : '0;
            end
            1, 2, 3: begin
                raw_t = htc_pkg::RAW_T_W'($urandom_range(9000, 3000));
                raw_h = htc_pkg::RAW_H_W'($urandom_range(3500, 100));
            end
            default: begin
                raw_t = htc_pkg::RAW_T_W'($urandom_range(16383));
                raw_h = htc_pkg::RAW_H_W'($urandom_range(4095));
            end
        endcase
        send_reading(raw_t, raw_h);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (htc_pkg::STAGES + 3) @(posedge aclk);
    endtask

    task automatic write_offset(input logic signed [htc_pkg::OFFSET_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        offset_now = value;
    endtask

    task automatic test_field_extremes();
        send_reading(14'd0, 12'd0);
        send_reading(14'd16383, 12'd4095);
        send_reading(14'd0, 12'd4095);
        send_reading(14'd16383, 12'd0);
        send_reading(14'd6470, 12'd1500);
        send_reading(14'd3970, 12'd2000);
        send_reading(14'd3975, 12'd1000);
        send_reading(14'd3965, 12'd1000);
        send_reading(14'd12000, 12'd3500);
        send_reading(14'd5000, 12'd60);
        wait_drained();
    endtask

    task automatic test_offset_extremes();
        logic signed [htc_pkg::OFFSET_W-1:0] offsets[4];
        offsets = '{-13'sd4096, 13'sd4095, -13'sd4010, -13'sd3940};
        foreach (offsets[i]) begin
            write_offset(offsets[i]);
            send_reading(14'd0, 12'd2000);
            send_reading(14'd16383, 12'd4095);
            send_reading(14'd4005, 12'd0);
        end
        write_offset(htc_pkg::OFFSET_RESET);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                       input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_offset(htc_pkg::OFFSET_W'($urandom_range(70) - 4010));
        repeat (count) send_random_reading();
        wait_drained();
    endtask

    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        fork
            begin
                hold_results <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_results <= 1'b0;
            end
            repeat (50) send_random_reading();
        join
        wait_drained();
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 5;
        recv_idle_pct = 30;
        repeat (20) send_random_reading();
        wait_drained();
        repeat (20) send_random_reading();
        wait_drained();
    endtask

    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        test_field_extremes();
        test_offset_extremes();
        test_random_traffic(200, 12, 47);
        test_random_traffic(200, 47, 12);
        test_random_traffic(200, 0, 0);
        test_result_backpressure();
        test_sender_pause();
        write_offset(-13'sd3970);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("humidity_temperature_compensation_top regression: pass");
        end else begin
            $display("humidity_temperature_compensation_top regression: fail");
        end
        $finish;
    end

    initial begin
        #6ms;
        $display("humidity_temperature_compensation_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/htc_pkg.sv
hdl/htc_poly.sv
hdl/htc_scale.sv
hdl/humidity_temperature_compensation_top.sv
sim/humidity_temperature_compensation_top_tb.sv
